### src/baro_pressure_temp_compensation_core_macros.svh
// assertion macros for the barometer compensation core
// included by the top level only, needs no package
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BPTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bptc_pkg.sv
// shared types, register codes and limits for the barometer compensation core
// no dependencies
`default_nettype none

package bptc_pkg;

    localparam int NUM_REGS     = 6;
    localparam int ADDR_W       = 5;
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 4;
    localparam int NUM_STAGES   = FRONT_STAGES + BACK_STAGES;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_SENS      = 3'd0;
    localparam logic [2:0] REG_OFF       = 3'd1;
    localparam logic [2:0] REG_TCS       = 3'd2;
    localparam logic [2:0] REG_TCO       = 3'd3;
    localparam logic [2:0] REG_TREF      = 3'd4;
    localparam logic [2:0] REG_TEMPSENS  = 3'd5;

    localparam logic signed [18:0] TEMP_BASE = 19'sd2000;
    localparam logic signed [18:0] TEMP_MIN  = -19'sd4000;
    localparam logic signed [18:0] TEMP_MAX  = 19'sd8500;
    localparam logic signed [24:0] PRES_MIN  = 25'sd1000;
    localparam logic signed [24:0] PRES_MAX  = 25'sd120000;

    typedef struct packed {
        logic [15:0] pressure_sensitivity;
        logic [15:0] pressure_offset;
        logic [15:0] sens_temp_coeff;
        logic [15:0] offset_temp_coeff;
        logic [15:0] reference_temperature;
        logic [15:0] temp_coeff_of_temp;
    } coef_t;

    // handoff from the coefficient stages to the pressure stages
    typedef struct packed {
        logic [23:0]        pressure_raw;
        logic signed [18:0] temp;
        logic signed [35:0] off;
        logic signed [34:0] sens;
    } front_t;

    typedef struct packed {
        logic [16:0]        pressure_pa;
        logic signed [14:0] temperature_centi;
    } result_t;

endpackage

`default_nettype wire

### src/baro_pressure_temp_compensation_core.sv
// an accepted input transaction passes through the coefficient stages, then the pressure stages, to m_tvalid
// throughput: one transaction per cycle while m_tready is high, set by the seven-stage multiply pipeline
// a stalled output lets empty stages upstream keep filling, so s_tready stays high
// until all seven stages hold a result
// reset (aresetn, synchronous, active low) clears the coefficients and all valid bits
`default_nettype none

`include "baro_pressure_temp_compensation_core_macros.svh"

module baro_pressure_temp_compensation_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // apb configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bptc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [47:0]                  s_tdata,  // [23:0] pressure_raw, [47:24] temperature_raw
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [31:0]                       m_tdata   // [14:0] temperature_centi, [31:15] pressure_pa
);

    localparam int NS = bptc_pkg::NUM_STAGES;
    localparam int NF = bptc_pkg::FRONT_STAGES;

    bptc_pkg::coef_t   coef;
    bptc_pkg::front_t  front;
    bptc_pkg::result_t result;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] stage_en;

    bptc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    bptc_coef_stage u_coef (
        .aclk            (aclk),
        .stage_en        (stage_en[NF-1:0]),
        .coef            (coef),
        .pressure_raw    (s_tdata[23:0]),
        .temperature_raw (s_tdata[47:24]),
        .front_out       (front)
    );

    bptc_pres_stage u_pres (
        .aclk     (aclk),
        .stage_en (stage_en[NS-1:NF]),
        .front_in (front),
        .result   (result)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = result;

    `BPTC_ASSERT_NOW(a_full_stall, aclk, aresetn, ($countones(valid_reg) == NS) && !m_tready, !s_tready, "input accepted while pipeline is full and stalled")
    `BPTC_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, valid_reg[0], "accepted transaction did not enter the first stage")
    `BPTC_ASSERT_NOW(a_temp_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[14:0]) >= -15'sd4000) && ($signed(m_tdata[14:0]) <= 15'sd8500), "temperature result outside clamp range")
    `BPTC_ASSERT_NOW(a_pres_range, aclk, aresetn, m_tvalid, (m_tdata[31:15] >= 17'd1000) && (m_tdata[31:15] <= 17'd120000), "pressure result outside clamp range")

endmodule

`default_nettype wire

### src/bptc_cfg_regs.sv
// apb register file holding the six calibration coefficients
// depends on bptc_pkg
`default_nettype none

module bptc_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bptc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output bptc_pkg::coef_t                   coef
);

    bptc_pkg::coef_t coef_reg;
    bptc_pkg::coef_t coef_next;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bptc_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            unique case (reg_idx)
                bptc_pkg::REG_SENS:     coef_next.pressure_sensitivity  = pwdata[15:0];
                bptc_pkg::REG_OFF:      coef_next.pressure_offset       = pwdata[15:0];
                bptc_pkg::REG_TCS:      coef_next.sens_temp_coeff       = pwdata[15:0];
                bptc_pkg::REG_TCO:      coef_next.offset_temp_coeff     = pwdata[15:0];
                bptc_pkg::REG_TREF:     coef_next.reference_temperature = pwdata[15:0];
                bptc_pkg::REG_TEMPSENS: coef_next.temp_coeff_of_temp    = pwdata[15:0];
                default:                coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            bptc_pkg::REG_SENS:     prdata = {16'd0, coef_reg.pressure_sensitivity};
            bptc_pkg::REG_OFF:      prdata = {16'd0, coef_reg.pressure_offset};
            bptc_pkg::REG_TCS:      prdata = {16'd0, coef_reg.sens_temp_coeff};
            bptc_pkg::REG_TCO:      prdata = {16'd0, coef_reg.offset_temp_coeff};
            bptc_pkg::REG_TREF:     prdata = {16'd0, coef_reg.reference_temperature};
            bptc_pkg::REG_TEMPSENS: prdata = {16'd0, coef_reg.temp_coeff_of_temp};
            default:                prdata = 32'd0;
        endcase
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

### src/bptc_coef_stage.sv
// stages one to three: temperature delta, coefficient products, temp/off/sens
// depends on bptc_pkg
`default_nettype none

module bptc_coef_stage (
    input  wire logic                               aclk,
    input  wire logic [bptc_pkg::FRONT_STAGES-1:0]  stage_en,
    input  wire bptc_pkg::coef_t                    coef,
    input  wire logic [23:0]                        pressure_raw,
    input  wire logic [23:0]                        temperature_raw,
    output bptc_pkg::front_t                        front_out
);

    // stage 1
    logic [23:0]        d1_s1_reg;
    logic signed [24:0] dt_s1_reg;
    logic signed [24:0] dt_next;

    // stage 2
    logic [23:0]        d1_s2_reg;
    logic signed [40:0] p_temp_reg, p_off_reg, p_sens_reg;
    logic signed [40:0] p_temp_next, p_off_next, p_sens_next;

    // stage 3
    bptc_pkg::front_t   front_reg;
    bptc_pkg::front_t   front_next;

    assign dt_next = $signed({1'b0, temperature_raw})
                   - $signed({1'b0, coef.reference_temperature, 8'd0});

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            d1_s1_reg <= pressure_raw;
            dt_s1_reg <= dt_next;
        end
    end

    assign p_temp_next = dt_s1_reg * $signed({1'b0, coef.temp_coeff_of_temp});
    assign p_off_next  = dt_s1_reg * $signed({1'b0, coef.offset_temp_coeff});
    assign p_sens_next = dt_s1_reg * $signed({1'b0, coef.sens_temp_coeff});

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            d1_s2_reg  <= d1_s1_reg;
            p_temp_reg <= p_temp_next;
            p_off_reg  <= p_off_next;
            p_sens_reg <= p_sens_next;
        end
    end

    // dropping low bits of a two's complement product floors toward minus infinity
    always_comb begin
        front_next.pressure_raw = d1_s2_reg;
        front_next.temp = bptc_pkg::TEMP_BASE + $signed(p_temp_reg[40:23]);
        front_next.off  = $signed({3'd0, coef.pressure_offset, 17'd0})
                        + $signed(p_off_reg[40:6]);
        front_next.sens = $signed({3'd0, coef.pressure_sensitivity, 16'd0})
                        + $signed(p_sens_reg[40:7]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            front_reg <= front_next;
        end
    end

    assign front_out = front_reg;

endmodule

`default_nettype wire

### src/bptc_pres_stage.sv
// stages four to seven: split pressure product, scale, offset, clamp
// depends on bptc_pkg
`default_nettype none

module bptc_pres_stage (
    input  wire logic                              aclk,
    input  wire logic [bptc_pkg::BACK_STAGES-1:0]  stage_en,
    input  wire bptc_pkg::front_t                  front_in,
    output bptc_pkg::result_t                      result
);

    // stage 4: d1 * sens as two partial products
    logic [40:0]        mlo_reg, mlo_next;
    logic signed [42:0] mhi_reg, mhi_next;
    logic signed [35:0] off_s4_reg;
    logic signed [14:0] temp_s4_reg, temp_next;

    // stage 5
    logic signed [59:0] prod_reg, prod_next;
    logic signed [35:0] off_s5_reg;
    logic signed [14:0] temp_s5_reg;

    // stage 6
    logic signed [39:0] diff_reg, diff_next;
    logic signed [14:0] temp_s6_reg;

    // stage 7
    bptc_pkg::result_t  result_reg, result_next;
    logic signed [24:0] pres_full;

    assign mlo_next = front_in.pressure_raw * front_in.sens[16:0];
    assign mhi_next = $signed({1'b0, front_in.pressure_raw}) * $signed(front_in.sens[34:17]);

    always_comb begin
        if (front_in.temp < bptc_pkg::TEMP_MIN) begin
            temp_next = bptc_pkg::TEMP_MIN[14:0];
        end else if (front_in.temp > bptc_pkg::TEMP_MAX) begin
            temp_next = bptc_pkg::TEMP_MAX[14:0];
        end else begin
            temp_next = front_in.temp[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mlo_reg     <= mlo_next;
            mhi_reg     <= mhi_next;
            off_s4_reg  <= front_in.off;
            temp_s4_reg <= temp_next;
        end
    end

    assign prod_next = $signed({mhi_reg, 17'd0}) + $signed({19'd0, mlo_reg});

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg    <= prod_next;
            off_s5_reg  <= off_s4_reg;
            temp_s5_reg <= temp_s4_reg;
        end
    end

    assign diff_next = $signed(prod_reg[59:21]) - off_s5_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            diff_reg    <= diff_next;
            temp_s6_reg <= temp_s5_reg;
        end
    end

    assign pres_full = $signed(diff_reg[39:15]);

    always_comb begin
        result_next.temperature_centi = temp_s6_reg;
        if (pres_full < bptc_pkg::PRES_MIN) begin
            result_next.pressure_pa = bptc_pkg::PRES_MIN[16:0];
        end else if (pres_full > bptc_pkg::PRES_MAX) begin
            result_next.pressure_pa = bptc_pkg::PRES_MAX[16:0];
        end else begin
            result_next.pressure_pa = pres_full[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
